@@ hdl/zpp_pkg.sv @@
`timescale 1ns / 1ps

package zpp_pkg;

  // default phase resolution in bits
  localparam int PHASE_BITS_DEF = 24;

  // one square-root cell per result bit of the 32-bit radius
  localparam int SQ_CELLS = 32;

  // polynomial steps of the quarter-wave sine
  localparam int HORNER_STEPS = 4;
  localparam int HORNER_DIV [HORNER_STEPS] = '{72, 42, 20, 6};

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CHIRP    = 2'd0;
  localparam logic [1:0] REG_SIZE     = 2'd1;
  localparam logic [1:0] REG_FREQ     = 2'd2;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  // beat moving through the square-root chain
  typedef struct packed {
    logic        vld;
    logic        mode;
    logic [31:0] r2;
    logic [31:0] nrest;
    logic [35:0] rem;
    logic [31:0] root;
  } zpp_sq_t;

  // sideband moving along the sine cells
  typedef struct packed {
    logic        vld;
    logic [1:0]  quad;
    logic [31:0] t2;
    logic [30:0] t;
  } zpp_side_t;

endpackage

@@ hdl/zone_plate_pattern.sv @@
`timescale 1ns / 1ps

// channel    | ports                                  | direction | handshake
// input      | start, busy, in_x_coord, in_y_coord    | in        | start & !busy
// result     | out_valid, out_intensity               | out       | one-cycle strobe
// config     | psel, penable, pwrite, paddr, pwdata,  | in/out    | APB write, pready high
//            | prdata, pready                         |           |
//
// One beat is taken every cycle; busy stays low.
// The pipeline runs through the 32-cell square-root chain, one cell per radius bit,
// plus the multiply stages and four three-stage sine cells.
// Synchronous reset clears all valid bits and the registers to their defaults.
// Results are strobed once and the receiver cannot stall them.

module zone_plate_pattern #(
  parameter int PHASE_BITS = zpp_pkg::PHASE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  output logic               out_valid,
  output logic        [15:0] out_intensity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [3:0] paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import zpp_pkg::*;

  localparam logic [31:0] P_MASK = 32'(~((64'd1 << (32 - PHASE_BITS)) - 64'd1));
  localparam int LAT = SQ_CELLS + 3 * HORNER_STEPS + 7;

  logic        chirp_r;
  logic [15:0] size_r, freq_r;
  logic [31:0] ss_r, sf_r;
  logic        wr_en;

  // configuration registers
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chirp_r <= 1'b0;
      size_r  <= 16'd256;
      freq_r  <= 16'd256;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CHIRP: chirp_r <= pwdata[0];
        REG_SIZE:  size_r  <= pwdata[15:0];
        REG_FREQ:  freq_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHIRP: prdata = {31'd0, chirp_r};
      REG_SIZE:  prdata = {16'd0, size_r};
      REG_FREQ:  prdata = {16'd0, freq_r};
      default:   prdata = 32'd0;
    endcase
  end

  // hold the scale products for the phase multiply
  always_ff @(posedge clk) begin
    ss_r <= 32'(size_r) * 32'(size_r);
    sf_r <= 32'(size_r) * 32'(freq_r);
  end

  // square the coordinates
  logic signed [31:0] xs, ys, xx, yy;
  logic        a_vld_r, a_mode_r;
  logic [30:0] xx_r, yy_r;

  always_comb begin
    xs = 32'(in_x_coord);
    ys = 32'(in_y_coord);
    xx = xs * xs;
    yy = ys * ys;
  end

  always_ff @(posedge clk) begin
    xx_r     <= xx[30:0];
    yy_r     <= yy[30:0];
    a_mode_r <= chirp_r;
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start & ~busy;
    end
  end

  // sum into r2 and feed the chain
  zpp_sq_t sq_nxt, sq_r;
  zpp_sq_t chain [SQ_CELLS+1];

  always_comb begin
    sq_nxt       = '0;
    sq_nxt.vld   = a_vld_r;
    sq_nxt.mode  = a_mode_r;
    sq_nxt.r2    = 32'(xx_r) + 32'(yy_r);
    sq_nxt.nrest = sq_nxt.r2;
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    if (!rst_n) begin
      sq_r.vld <= 1'b0;
    end
  end

  assign chain[0] = sq_r;

  for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
    zpp_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // phase multiply
  zpp_sq_t     sq_out;
  logic        m_vld_r, m_mode_r;
  logic [63:0] ph_r;

  assign sq_out = chain[SQ_CELLS];

  always_ff @(posedge clk) begin
    ph_r     <= sq_out.mode ? 64'(ss_r) * 64'(sq_out.r2) : 64'(sf_r) * 64'(sq_out.root);
    m_mode_r <= sq_out.mode;
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= sq_out.vld;
    end
  end

  // keep the phase fraction as a 32-bit turn
  logic        p_vld_r;
  logic [31:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= (m_mode_r ? ph_r[45:14] : ph_r[46:15]) & P_MASK;
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= m_vld_r;
    end
  end

  // mirror into the quadrant and turn it into radians
  logic [30:0] ang;
  logic [61:0] ta;
  logic        t_vld_r;
  logic [1:0]  t_quad_r;
  logic [30:0] t_r;

  always_comb begin
    ang = p_r[30] ? (ONE_Q30 - 31'(p_r[29:0])) : 31'(p_r[29:0]);
    ta  = 62'(ang) * 62'(HALF_PI_Q30);
  end

  always_ff @(posedge clk) begin
    t_r      <= ta[60:30];
    t_quad_r <= p_r[31:30];
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= p_vld_r;
    end
  end

  // square the angle
  logic [61:0] tt;
  zpp_side_t   side_r;

  assign tt = 62'(t_r) * 62'(t_r);

  always_ff @(posedge clk) begin
    side_r.quad <= t_quad_r;
    side_r.t    <= t_r;
    side_r.t2   <= tt[61:30];
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else begin
      side_r.vld <= t_vld_r;
    end
  end

  // Horner steps of the sine polynomial
  zpp_side_t   hs [HORNER_STEPS+1];
  logic [31:0] hv [HORNER_STEPS+1];

  assign hs[0] = side_r;
  assign hv[0] = side_r.t2;

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_hn
    zpp_horner_cell #(
      .DIV  (HORNER_DIV[g]),
      .LAST (g == HORNER_STEPS - 1)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (hs[g]),
      .v_i    (hv[g]),
      .side_o (hs[g+1]),
      .v_o    (hv[g+1])
    );
  end

  // offset, round and saturate the intensity
  logic [31:0] s_fin;
  logic [32:0] v_fin;
  logic [33:0] r_fin;
  logic [15:0] int_nxt;
  logic        out_valid_r;
  logic [15:0] out_int_r;

  always_comb begin
    s_fin = hv[HORNER_STEPS];
    if (hs[HORNER_STEPS].quad[1]) begin
      v_fin = (s_fin > 32'(ONE_Q30)) ? 33'd0 : 33'(ONE_Q30) - 33'(s_fin);
    end else begin
      v_fin = 33'(ONE_Q30) + 33'(s_fin);
    end
    r_fin   = (34'(v_fin) + 34'd16384) >> 15;
    int_nxt = (r_fin > 34'd65535) ? 16'hFFFF : r_fin[15:0];
  end

  always_ff @(posedge clk) begin
    out_int_r <= int_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hs[HORNER_STEPS].vld;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_intensity = out_int_r;

  // every accepted beat comes out after a fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat produced no result");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_root_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_out.vld && !sq_out.mode) |->
      (64'(sq_out.root) * 64'(sq_out.root) <= {sq_out.r2, 32'd0}))
    else $error("square root too large");

  a_root_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_out.vld && !sq_out.mode) |->
      ((66'(sq_out.root) + 66'd1) * (66'(sq_out.root) + 66'd1) > 66'({sq_out.r2, 32'd0})))
    else $error("square root too small");

endmodule

@@ hdl/zpp_sqrt_cell.sv @@
`timescale 1ns / 1ps

module zpp_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  zpp_pkg::zpp_sq_t cell_i,
  output zpp_pkg::zpp_sq_t cell_o
);
  import zpp_pkg::*;

  logic [35:0] trial;
  logic [35:0] tst;
  logic        fit;
  zpp_sq_t     cell_nxt;
  zpp_sq_t     cell_r;

  // bring down two radicand bits and try one more root bit
  always_comb begin
    trial = {cell_i.rem[33:0], cell_i.nrest[31:30]};
    tst   = {2'b00, cell_i.root, 2'b01};
    fit   = (trial >= tst);
    cell_nxt       = cell_i;
    cell_nxt.nrest = {cell_i.nrest[29:0], 2'b00};
    cell_nxt.rem   = fit ? (trial - tst) : trial;
    cell_nxt.root  = {cell_i.root[30:0], fit};
  end

  // hand the beat to the next cell
  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end
  end

  assign cell_o = cell_r;

endmodule

@@ hdl/zpp_horner_cell.sv @@
`timescale 1ns / 1ps

module zpp_horner_cell #(
  parameter int DIV  = 72,
  parameter bit LAST = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  zpp_pkg::zpp_side_t side_i,
  input  logic [31:0]        v_i,
  output zpp_pkg::zpp_side_t side_o,
  output logic [31:0]        v_o
);
  import zpp_pkg::*;

  localparam logic [31:0] RECIP = 32'((64'd1 << 34) / DIV);
  localparam logic [35:0] DIV_W = 36'(DIV);

  zpp_side_t   s0_r, s1_r, s2_r;
  logic [31:0] v0_r;
  logic [29:0] q0_nxt, q0_r;
  logic [63:0] rprod;
  logic [35:0] rem;
  logic [29:0] q;
  logic [30:0] h_nxt, h_r;
  logic [31:0] m;
  logic [62:0] prod;
  logic [31:0] v2_nxt, v2_r;

  // estimate the quotient by reciprocal
  always_comb begin
    rprod  = 64'(v_i) * 64'(RECIP);
    q0_nxt = rprod[63:34];
  end

  // correct the estimate by one and form h
  always_comb begin
    rem   = 36'(v0_r) - 36'(q0_r) * DIV_W;
    q     = q0_r + 30'(rem >= DIV_W);
    h_nxt = ONE_Q30 - 31'(q);
  end

  // scale h by t2, or by t in the last step
  always_comb begin
    m      = LAST ? {1'b0, s1_r.t} : s1_r.t2;
    prod   = 63'(m) * 63'(h_r);
    v2_nxt = prod[61:30];
  end

  always_ff @(posedge clk) begin
    s0_r  <= side_i;
    v0_r  <= v_i;
    q0_r  <= q0_nxt;
    s1_r  <= s0_r;
    h_r   <= h_nxt;
    s2_r  <= s1_r;
    v2_r  <= v2_nxt;
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end
  end

  assign side_o = s2_r;
  assign v_o    = v2_r;

endmodule
